// ----- rtl/core/tpct_pkg.sv -----
// Shared types and constants for the two-phase countdown timer.
// No dependencies; every other file refers to it by scoped names.
package tpct_pkg;

  localparam int unsigned NowW  = 32;
  localparam int unsigned LenW  = 31;
  localparam int unsigned SessW = 16;
  localparam int unsigned SecW  = 22;
  localparam int unsigned ModeW = 3;

  localparam logic [LenW-1:0]  LenMax      = {LenW{1'b1}};
  localparam logic [LenW-1:0]  FocusReset  = 31'd1500000;
  localparam logic [LenW-1:0]  BreakReset  = 31'd300000;
  localparam logic [SessW-1:0] SessMax     = {SessW{1'b1}};

  // ceil(x / 1000) = floor((x + 999) * Recip1000 / 2^Recip1000Sh) for 32-bit sums
  localparam logic [NowW-1:0]  RoundUp1000 = 32'd999;
  localparam int unsigned      RecipW      = 29;
  localparam logic [RecipW-1:0] Recip1000  = 29'd274877907;
  localparam int unsigned      Recip1000Sh = 38;

  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FOCUS_LEN = 1'd0,
    CFG_BREAK_LEN = 1'd1
  } cfg_idx_e;

  typedef enum logic [ModeW-1:0] {
    MODE_TICK   = 3'd0,
    MODE_START  = 3'd1,
    MODE_PAUSE  = 3'd2,
    MODE_RESUME = 3'd3,
    MODE_NEXT   = 3'd4,
    MODE_RESET  = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    RUN_IDLE   = 2'd0,
    RUN_ACTIVE = 2'd1,
    RUN_PAUSED = 2'd2,
    RUN_ALERT  = 2'd3
  } run_e;

  // Status after one command, before the seconds conversion
  typedef struct packed {
    logic             accepted;
    run_e             run_state;
    logic             phase_now;
    logic [SessW-1:0] sessions_done;
    logic [LenW-1:0]  left_ms;
  } stat_t;

endpackage

// ----- rtl/core/tpct_cmd_if.sv -----
// Command channel of the countdown timer: valid/ready plus mode and timestamp.
// Depends on tpct_pkg for field widths.
interface tpct_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [tpct_pkg::ModeW-1:0]   mode;
  logic [tpct_pkg::NowW-1:0]    now_ms;

  modport source (output valid, output mode, output now_ms, input ready);
  modport sink   (input valid, input mode, input now_ms, output ready);
endinterface

// ----- rtl/core/tpct_res_if.sv -----
// Status channel of the countdown timer: valid/ready plus the status fields.
// Depends on tpct_pkg for field widths.
interface tpct_res_if;
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic [1:0]                   run_state;
  logic                         phase_now;
  logic [tpct_pkg::SessW-1:0]   sessions_done;
  logic [tpct_pkg::LenW-1:0]    left_ms;
  logic [tpct_pkg::SecW-1:0]    left_s;

  modport source (output valid, output accepted, output run_state, output phase_now,
                  output sessions_done, output left_ms, output left_s, input ready);
  modport sink   (input valid, input accepted, input run_state, input phase_now,
                  input sessions_done, input left_ms, input left_s, output ready);
endinterface

// ----- rtl/core/tpct_sec_stage.sv -----
// Output stage: converts milliseconds left to seconds rounded up and holds
// the status request for the sink. Depends on tpct_pkg and tpct_res_if.
module tpct_sec_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  tpct_pkg::stat_t   stat_i,
  tpct_res_if.source        res_o
);

  logic [tpct_pkg::NowW-1:0]                  sum;
  logic [tpct_pkg::NowW+tpct_pkg::RecipW-1:0] prod;
  logic [tpct_pkg::SecW-1:0]                  secs;
  logic                                       load;

  logic                      valid_q;
  tpct_pkg::stat_t           stat_q;
  logic [tpct_pkg::SecW-1:0] secs_q;

  // ceil(ms / 1000) by reciprocal multiply
  assign sum  = {1'b0, stat_i.left_ms} + tpct_pkg::RoundUp1000;
  assign prod = {{tpct_pkg::RecipW{1'b0}}, sum} *
                {{tpct_pkg::NowW{1'b0}}, tpct_pkg::Recip1000};
  assign secs = prod[tpct_pkg::Recip1000Sh +: tpct_pkg::SecW];

  assign ready_o = !valid_q || res_o.ready;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      stat_q <= stat_i;
      secs_q <= secs;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.accepted      = stat_q.accepted;
  assign res_o.run_state     = stat_q.run_state;
  assign res_o.phase_now     = stat_q.phase_now;
  assign res_o.sessions_done = stat_q.sessions_done;
  assign res_o.left_ms       = stat_q.left_ms;
  assign res_o.left_s        = secs_q;

endmodule

// ----- rtl/core/two_phase_countdown_timer.sv -----
// Two-phase countdown timer: one command per cycle unless the status sink stalls.
// Throughput: one request per cycle while not stalled; the state update and its status land in
// the first register, the seconds multiply in the output register.
// Reset (rst_ni low, asynchronous): idle, focus phase, zero sessions, lengths
// back to 1500000 / 300000 ms, both stages empty.
// Depends on tpct_pkg, tpct_cmd_if, tpct_res_if and tpct_sec_stage.
module two_phase_countdown_timer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tpct_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tpct_pkg::LenW-1:0]       cfg_wdata_i,
  tpct_cmd_if.sink                        cmd_i,
  tpct_res_if.source                      res_o
);

  localparam int unsigned NW = tpct_pkg::NowW;
  localparam int unsigned LW = tpct_pkg::LenW;
  localparam int unsigned SW = tpct_pkg::SessW;

  // configuration
  logic [LW-1:0] focus_q, break_q;

  // timer state
  tpct_pkg::run_e run_q, run_d;
  logic           phase_q, phase_d;
  logic [NW-1:0]  deadline_q, deadline_d;
  logic [LW-1:0]  paused_q, paused_d;
  logic [SW-1:0]  sess_q, sess_d;

  // first stage
  logic            s1_valid_q;
  tpct_pkg::stat_t s1_stat_q;
  tpct_pkg::stat_t stat_d;
  logic            s2_ready;
  logic            in_fire;

  tpct_pkg::mode_e mode;
  logic [NW-1:0]   now;
  logic [LW-1:0]   len_cur, len_other, add_val, run_left, sat_cur, left_d;
  logic [NW-1:0]   diff_cur, past_cur, dl_sum;
  logic            reached_cur, tick_fire, entered, ok;
  logic [SW-1:0]   sess_inc;

  assign mode = tpct_pkg::mode_e'(cmd_i.mode);
  assign now  = cmd_i.now_ms;

  assign cmd_i.ready = !s1_valid_q || s2_ready;
  assign in_fire     = cmd_i.valid && cmd_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focus_q <= tpct_pkg::FocusReset;
      break_q <= tpct_pkg::BreakReset;
    end else if (cfg_we_i) begin
      case (tpct_pkg::cfg_idx_e'(cfg_idx_i))
        tpct_pkg::CFG_FOCUS_LEN: focus_q <= cfg_wdata_i;
        tpct_pkg::CFG_BREAK_LEN: break_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign len_cur   = phase_q ? break_q : focus_q;
  assign len_other = phase_q ? focus_q : break_q;

  // wrap-safe deadline compare
  assign past_cur    = now - deadline_q;
  assign diff_cur    = deadline_q - now;
  assign reached_cur = !past_cur[NW-1];
  // not reached means diff in 1..2^31; only 2^31 needs the clamp
  assign sat_cur     = diff_cur[NW-1] ? tpct_pkg::LenMax : diff_cur[LW-1:0];
  assign run_left    = reached_cur ? '0 : sat_cur;
  assign tick_fire   = (run_q == tpct_pkg::RUN_ACTIVE) && reached_cur;
  assign sess_inc    = (sess_q != tpct_pkg::SessMax) ? sess_q + 1'b1 : sess_q;

  always_comb begin
    case (mode)
      tpct_pkg::MODE_RESUME: add_val = paused_q;
      tpct_pkg::MODE_NEXT:   add_val = len_other;
      default:               add_val = len_cur;
    endcase
  end

  assign dl_sum = now + {1'b0, add_val};

  always_comb begin
    run_d      = run_q;
    phase_d    = phase_q;
    deadline_d = deadline_q;
    paused_d   = paused_q;
    sess_d     = sess_q;
    ok         = 1'b0;
    entered    = 1'b0;
    case (mode)
      tpct_pkg::MODE_TICK: begin
        ok = 1'b1;
        if (tick_fire) begin
          run_d    = tpct_pkg::RUN_ALERT;
          paused_d = '0;
          if (!phase_q) sess_d = sess_inc;
        end
      end
      tpct_pkg::MODE_START: begin
        if (run_q == tpct_pkg::RUN_IDLE) begin
          deadline_d = dl_sum;
          paused_d   = '0;
          run_d      = tpct_pkg::RUN_ACTIVE;
          ok         = 1'b1;
          entered    = 1'b1;
        end
      end
      tpct_pkg::MODE_PAUSE: begin
        if (run_q == tpct_pkg::RUN_ACTIVE) begin
          if (tick_fire) begin
            // phase ended on the implied tick: keep its effect, reject the pause
            run_d    = tpct_pkg::RUN_ALERT;
            paused_d = '0;
            if (!phase_q) sess_d = sess_inc;
          end else begin
            paused_d = sat_cur;
            run_d    = tpct_pkg::RUN_PAUSED;
            ok       = 1'b1;
          end
        end
      end
      tpct_pkg::MODE_RESUME: begin
        if (run_q == tpct_pkg::RUN_PAUSED) begin
          deadline_d = dl_sum;
          run_d      = tpct_pkg::RUN_ACTIVE;
          ok         = 1'b1;
          entered    = 1'b1;
        end
      end
      tpct_pkg::MODE_NEXT: begin
        if (run_q == tpct_pkg::RUN_ALERT) begin
          phase_d    = !phase_q;
          deadline_d = dl_sum;
          paused_d   = '0;
          run_d      = tpct_pkg::RUN_ACTIVE;
          ok         = 1'b1;
          entered    = 1'b1;
        end
      end
      tpct_pkg::MODE_RESET: begin
        run_d      = tpct_pkg::RUN_IDLE;
        phase_d    = 1'b0;
        deadline_d = '0;
        paused_d   = '0;
        sess_d     = '0;
        ok         = 1'b1;
      end
      default: ;
    endcase
  end

  // time left after the command; a fresh deadline is exactly add_val away
  always_comb begin
    case (run_d)
      tpct_pkg::RUN_IDLE:   left_d = phase_d ? break_q : focus_q;
      tpct_pkg::RUN_PAUSED: left_d = paused_d;
      tpct_pkg::RUN_ACTIVE: left_d = entered ? add_val : run_left;
      default:              left_d = '0;
    endcase
  end

  always_comb begin
    stat_d.accepted      = ok;
    stat_d.run_state     = run_d;
    stat_d.phase_now     = phase_d;
    stat_d.sessions_done = sess_d;
    stat_d.left_ms       = left_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= tpct_pkg::RUN_IDLE;
      phase_q    <= 1'b0;
      deadline_q <= '0;
      paused_q   <= '0;
      sess_q     <= '0;
    end else if (in_fire) begin
      run_q      <= run_d;
      phase_q    <= phase_d;
      deadline_q <= deadline_d;
      paused_q   <= paused_d;
      sess_q     <= sess_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      s1_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_stat_q <= stat_d;
    end
  end

  tpct_sec_stage u_sec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .ready_o (s2_ready),
    .stat_i  (s1_stat_q),
    .res_o   (res_o)
  );

endmodule
